/* hdl/alo_pkg.sv */
// Shared types and constants of the stereo loop recorder.
// Used by alo_ctrl, alo_lane and audio_looper_overdub_top; depends on nothing.
package alo_pkg;

    // Loop modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_REC  = 2'd1;
    localparam logic [1:0] MODE_PLAY = 2'd2;
    localparam logic [1:0] MODE_DUB  = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REC_ENABLE = 2'd2;

    // Register widths and reset values
    localparam int SPEED_W = 17;
    localparam int GAIN_W  = 16;
    localparam int CFG_DATA_W = 17;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 17'd65536;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd32768;

    // Fraction bits of the play position
    localparam int FRAC_W = 16;

    // Per-step controls from the sequencer to each channel lane
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic              wr_avg;
        logic              ld_in;
        logic              ld_a;
        logic              ld_mul;
        logic              ld_sum;
        logic              ld_gain;
        logic [FRAC_W-1:0] frac;
    } lane_ctl_t;

    // Status from the sequencer to the output stage
    typedef struct packed {
        logic       fin;
        logic       play;
        logic [1:0] mode;
    } ctrl_stat_t;

endpackage

/* hdl/audio_looper_overdub_top.sv */
// Top level of the stereo loop recorder with overdub: configuration
// registers, the sequencer, two channel lanes and the output stage.
// Depends on alo_pkg, alo_ctrl and alo_lane.

// A sample beat in play or overdub mode runs through the lane stages: the
// single-port sample memory of each lane is read for both interpolation
// taps in turn, then for the overdub entry in overdub mode with recording
// enabled, and the multiply, round and gain stages follow one per cycle; the
// overdub write follows the entry read. Button beats and sample beats in
// idle or record mode skip the lane stages. A new input beat is taken once
// the previous result has moved into the output register. The sample memory
// is not cleared; entries are defined once recorded. Results carry zeros for
// button beats, outside play and overdub mode and for an empty loop.
module audio_looper_overdub_top #(
    parameter int LOOP_DEPTH  = 524288,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // in_left, in_right
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
    // operation
    input  logic                                      s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // out_left, out_right, loop_mode
    output logic [((2*SAMPLE_BITS+2+7)/8)*8-1:0]      m_axis_tdata,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [alo_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [alo_pkg::CFG_DATA_W-1:0]            cfg_data
);

    localparam int S      = SAMPLE_BITS;
    localparam int ADDR_W = $clog2(LOOP_DEPTH);
    localparam int OUT_W  = ((2*SAMPLE_BITS+2+7)/8)*8;

    logic [alo_pkg::SPEED_W-1:0] speed_reg;
    logic [alo_pkg::GAIN_W-1:0]  gain_reg;
    logic                        rec_en_reg;
    logic                        m_valid_reg;
    logic [OUT_W-1:0]            m_data_reg;

    alo_pkg::lane_ctl_t  lane_ctl;
    alo_pkg::ctrl_stat_t stat;
    logic [ADDR_W-1:0]   addr;
    logic [S-1:0]        y_left;
    logic [S-1:0]        y_right;
    logic                out_free;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg  <= alo_pkg::SPEED_RESET;
            gain_reg   <= alo_pkg::GAIN_RESET;
            rec_en_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                alo_pkg::CFG_SPEED:      speed_reg  <= cfg_data[alo_pkg::SPEED_W-1:0];
                alo_pkg::CFG_OUT_GAIN:   gain_reg   <= cfg_data[alo_pkg::GAIN_W-1:0];
                alo_pkg::CFG_REC_ENABLE: rec_en_reg <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    alo_ctrl #(
        .LOOP_DEPTH (LOOP_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (s_axis_tuser),
        .out_free   (out_free),
        .speed      (speed_reg),
        .rec_enable (rec_en_reg),
        .lane_ctl   (lane_ctl),
        .addr       (addr),
        .stat       (stat)
    );

    alo_lane #(
        .LOOP_DEPTH  (LOOP_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (lane_ctl),
        .addr      (addr),
        .in_sample (s_axis_tdata[S-1:0]),
        .gain      (gain_reg),
        .result    (y_left)
    );

    alo_lane #(
        .LOOP_DEPTH  (LOOP_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (lane_ctl),
        .addr      (addr),
        .in_sample (s_axis_tdata[2*S-1:S]),
        .gain      (gain_reg),
        .result    (y_right)
    );

    // Merge the lanes into the output beat; hold it until taken
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (stat.fin)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.fin)
        begin
            if (stat.play)
            begin
                m_data_reg <= OUT_W'({stat.mode, y_right, y_left});
            end
            else
            begin
                m_data_reg <= OUT_W'({stat.mode, {(2*S){1'b0}}});
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

/* hdl/alo_lane.sv */
// One channel lane: sample memory, interpolation, gain and overdub averaging.
// Depends on alo_pkg; controlled step by step by alo_ctrl.
module alo_lane #(
    parameter int LOOP_DEPTH  = 524288,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  alo_pkg::lane_ctl_t             ctl,
    input  logic [$clog2(LOOP_DEPTH)-1:0]  addr,
    input  logic [SAMPLE_BITS-1:0]         in_sample,
    input  logic [alo_pkg::GAIN_W-1:0]     gain,
    output logic [SAMPLE_BITS-1:0]         result
);

    localparam int S      = SAMPLE_BITS;
    localparam logic signed [S+1:0] Y_MAX = (S+2)'((64'd1 << (S - 1)) - 64'd1);
    localparam logic signed [S+1:0] Y_MIN = -Y_MAX - (S+2)'(1);

    logic [S-1:0] mem [LOOP_DEPTH];
    logic [S-1:0] rdata_reg;
    logic [S-1:0] in_reg;
    logic [S-1:0] a_reg;
    logic signed [S+17:0] prod_reg;
    logic signed [S-1:0]  v_reg;
    logic signed [S+16:0] g_reg;

    logic signed [S:0]    diff;
    logic signed [S+17:0] acc;
    logic signed [S+16:0] rnd;
    logic signed [S+1:0]  y_full;
    logic [S:0]           avg_sum;
    logic [S-1:0]         wr_data;

    // Averaged overdub entry or plain recorded input
    assign avg_sum = {rdata_reg[S-1], rdata_reg} + {in_reg[S-1], in_reg};
    assign wr_data = ctl.wr_avg ? avg_sum[S:1] : in_sample;

    // Sample memory: one port, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    // Interpolate as a*2^16 + (b - a)*f, round, then scale by the gain
    assign diff   = $signed({rdata_reg[S-1], rdata_reg}) - $signed({a_reg[S-1], a_reg});
    assign acc    = $signed({{2{a_reg[S-1]}}, a_reg, 16'h0}) + prod_reg
                    + $signed((S+18)'(32768));
    assign rnd    = g_reg + $signed((S+17)'(16384));
    assign y_full = rnd[S+16:15];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg   <= '0;
            a_reg    <= '0;
            prod_reg <= '0;
            v_reg    <= '0;
            g_reg    <= '0;
        end
        else
        begin
            if (ctl.ld_in)
            begin
                in_reg <= in_sample;
            end
            if (ctl.ld_a)
            begin
                a_reg <= rdata_reg;
            end
            if (ctl.ld_mul)
            begin
                prod_reg <= diff * $signed({1'b0, ctl.frac});
            end
            if (ctl.ld_sum)
            begin
                v_reg <= acc[S+15:16];
            end
            if (ctl.ld_gain)
            begin
                g_reg <= v_reg * $signed({1'b0, gain});
            end
        end
    end

    // Saturate to the sample range
    always_comb
    begin
        if (y_full > Y_MAX)
        begin
            result = Y_MAX[S-1:0];
        end
        else if (y_full < Y_MIN)
        begin
            result = Y_MIN[S-1:0];
        end
        else
        begin
            result = y_full[S-1:0];
        end
    end

endmodule

/* hdl/alo_ctrl.sv */
// Sequencer of the loop recorder: mode, record count, play position and the
// per-step lane controls. Depends on alo_pkg.
module alo_ctrl #(
    parameter int LOOP_DEPTH = 524288
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_op,
    input  logic                           out_free,
    input  logic [alo_pkg::SPEED_W-1:0]    speed,
    input  logic                           rec_enable,
    output alo_pkg::lane_ctl_t             lane_ctl,
    output logic [$clog2(LOOP_DEPTH)-1:0]  addr,
    output alo_pkg::ctrl_stat_t            stat
);

    localparam int ADDR_W = $clog2(LOOP_DEPTH);
    localparam int CNT_W  = $clog2(LOOP_DEPTH + 1);
    localparam int FW     = alo_pkg::FRAC_W;
    localparam int POS_W  = CNT_W + FW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD_A = 3'd1;
    localparam logic [2:0] ST_RD_B = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_GAIN = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       mode_reg, mode_next;
    logic [CNT_W-1:0] rec_count_reg, rec_count_next;
    logic [CNT_W-1:0] loop_len_reg, loop_len_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W:0]   sum_reg, sum_next;
    logic             play_reg, play_next;
    logic             dub_reg, dub_next;

    logic             accept;
    logic             playing;
    logic             rec_write;
    logic [CNT_W-1:0] i_int;
    logic [CNT_W-1:0] i_inc;
    logic [CNT_W-1:0] j_int;
    logic [POS_W:0]   span;
    logic [POS_W:0]   wrapped;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_ready && in_valid;
    assign playing  = ((mode_reg == alo_pkg::MODE_PLAY) || (mode_reg == alo_pkg::MODE_DUB))
                      && (loop_len_reg != '0);
    assign rec_write = accept && !in_op && rec_enable && (mode_reg == alo_pkg::MODE_REC)
                       && (rec_count_reg < CNT_W'(LOOP_DEPTH));

    // Read indexes; the position stays below the loop span while speed <= span
    assign i_int   = pos_reg[POS_W-1:FW];
    assign i_inc   = i_int + CNT_W'(1);
    assign j_int   = (i_inc == loop_len_reg) ? '0 : i_inc;
    assign span    = {1'b0, loop_len_reg, {FW{1'b0}}};
    assign wrapped = (sum_reg >= span) ? (sum_reg - span) : sum_reg;

    // Step the sequence and the loop state
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        rec_count_next = rec_count_reg;
        loop_len_next  = loop_len_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        play_next      = play_reg;
        dub_next       = dub_reg;
        lane_ctl       = '0;
        lane_ctl.frac  = pos_reg[FW-1:0];
        addr           = rec_count_reg[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_FIN;
                    play_next  = 1'b0;
                    dub_next   = 1'b0;
                    if (in_op)
                    begin
                        case (mode_reg)
                            alo_pkg::MODE_IDLE:
                            begin
                                rec_count_next = '0;
                                mode_next      = alo_pkg::MODE_REC;
                            end
                            alo_pkg::MODE_REC:
                            begin
                                loop_len_next = rec_count_reg;
                                pos_next      = '0;
                                mode_next     = alo_pkg::MODE_PLAY;
                            end
                            alo_pkg::MODE_PLAY:
                            begin
                                mode_next = alo_pkg::MODE_DUB;
                            end
                            default:
                            begin
                                mode_next = alo_pkg::MODE_PLAY;
                            end
                        endcase
                    end
                    else
                    begin
                        lane_ctl.ld_in = 1'b1;
                        if (playing)
                        begin
                            state_next = ST_RD_A;
                            play_next  = 1'b1;
                            dub_next   = rec_enable && (mode_reg == alo_pkg::MODE_DUB);
                        end
                        if (rec_write)
                        begin
                            lane_ctl.wr_en = 1'b1;
                            rec_count_next = rec_count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_RD_A:
            begin
                lane_ctl.rd_en = 1'b1;
                addr           = i_int[ADDR_W-1:0];
                sum_next       = {1'b0, pos_reg} + (POS_W+1)'(speed);
                state_next     = ST_RD_B;
            end
            ST_RD_B:
            begin
                lane_ctl.rd_en = 1'b1;
                lane_ctl.ld_a  = 1'b1;
                addr           = j_int[ADDR_W-1:0];
                sum_next       = wrapped;
                state_next     = ST_MUL;
            end
            ST_MUL:
            begin
                lane_ctl.ld_mul = 1'b1;
                pos_next        = wrapped[POS_W-1:0];
                state_next      = ST_SUM;
            end
            ST_SUM:
            begin
                // fetch the entry at the advanced position for overdub
                lane_ctl.ld_sum = 1'b1;
                lane_ctl.rd_en  = dub_reg;
                addr            = pos_reg[FW+ADDR_W-1:FW];
                state_next      = ST_GAIN;
            end
            ST_GAIN:
            begin
                lane_ctl.ld_gain = 1'b1;
                lane_ctl.wr_en   = dub_reg;
                lane_ctl.wr_avg  = 1'b1;
                addr             = pos_reg[FW+ADDR_W-1:FW];
                state_next       = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= alo_pkg::MODE_IDLE;
            rec_count_reg <= '0;
            loop_len_reg  <= '0;
            pos_reg       <= '0;
            play_reg      <= 1'b0;
            dub_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            rec_count_reg <= rec_count_next;
            loop_len_reg  <= loop_len_next;
            pos_reg       <= pos_next;
            play_reg      <= play_next;
            dub_reg       <= dub_next;
        end
    end

    // Position sum is pure datapath
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign stat.fin  = (state_reg == ST_FIN) && out_free;
    assign stat.play = play_reg;
    assign stat.mode = mode_reg;

endmodule
